// ===== hw/rtl/utfwc_pkg.sv =====
package utfwc_pkg;

   localparam int ByteW      = 8;
   localparam int CodeW      = 21;
   localparam int MaxResults = 5;
   localparam int CountW     = $clog2(MaxResults + 1);

   localparam logic [ByteW-1:0] SpaceByte = 8'h20;
   localparam logic [CodeW-1:0] MaxCode   = 21'h10ffff;
   localparam logic [CodeW-1:0] SurrLo    = 21'h00d800;
   localparam logic [CodeW-1:0] SurrHi    = 21'h00dfff;
   localparam logic [CodeW-1:0] Min2      = 21'h000080;
   localparam logic [CodeW-1:0] Min3      = 21'h000800;
   localparam logic [CodeW-1:0] Min4      = 21'h010000;

   // One input byte's worth of results, emitted one per cycle while rsp_stall is low.
   typedef struct packed {
      logic [MaxResults-1:0][ByteW-1:0] data;
      logic [CountW-1:0]                count;
      logic                             byte_valid;
      logic                             end_text;
      logic                             bad;
   } burst_type;

   function automatic logic is_space(input logic [CodeW-1:0] v);
      return v inside {[21'h09:21'h0d], [21'h1c:21'h20], 21'h85, 21'ha0, 21'h1680,
                       [21'h2000:21'h200a], 21'h2028, 21'h2029, 21'h202f,
                       21'h205f, 21'h3000};
   endfunction

endpackage

// ===== hw/rtl/utfwc_decode.sv =====
module utfwc_decode (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_in_byte,
   input  logic                    req_last_byte,
   input  logic                    load_ok,
   output logic                    burst_valid,
   output utfwc_pkg::burst_type    burst
);
   import utfwc_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   logic [ByteW-1:0]      byte_ff;
   logic                  last_ff;

   logic [CodeW-1:0]      acc_ff, acc_in;
   logic [1:0]            left_ff, left_in;
   logic [2:0]            seqlen_ff, seqlen_in;
   logic [2:0][ByteW-1:0] held_ff, held_in;
   logic                  seen_ff, seen_in;
   logic                  pend_ff, pend_in;
   logic                  err_ff, err_in;

   logic                  advance;
   logic                  accept;

   always_comb begin
      logic                  whole;
      logic [2:0]            seqlen_whole;
      logic [2:0]            idx;
      logic                  emit_text;
      logic                  emit_space;
      logic [3:0][ByteW-1:0] c;

      acc_in       = acc_ff;
      left_in      = left_ff;
      seqlen_in    = seqlen_ff;
      held_in      = held_ff;
      seen_in      = seen_ff;
      pend_in      = pend_ff;
      err_in       = err_ff;
      whole        = 1'b0;
      idx          = seqlen_ff - {1'b0, left_ff};
      emit_text    = 1'b0;
      emit_space   = 1'b0;
      burst        = '0;

      if (!err_ff) begin
         if (left_ff == 2'd0) begin
            if (!byte_ff[7]) begin
               acc_in    = {13'b0, byte_ff};
               seqlen_in = 3'd1;
               whole     = 1'b1;
            end else if (byte_ff[7:5] == 3'b110) begin
               acc_in     = {16'b0, byte_ff[4:0]};
               seqlen_in  = 3'd2;
               left_in    = 2'd1;
               held_in[0] = byte_ff;
            end else if (byte_ff[7:4] == 4'b1110) begin
               acc_in     = {17'b0, byte_ff[3:0]};
               seqlen_in  = 3'd3;
               left_in    = 2'd2;
               held_in[0] = byte_ff;
            end else if (byte_ff[7:3] == 5'b11110) begin
               acc_in     = {18'b0, byte_ff[2:0]};
               seqlen_in  = 3'd4;
               left_in    = 2'd3;
               held_in[0] = byte_ff;
            end else begin
               err_in = 1'b1;
            end
         end else if (byte_ff[7:6] != 2'b10) begin
            err_in = 1'b1;
         end else begin
            acc_in = {acc_ff[CodeW-7:0], byte_ff[5:0]};
            if (left_ff > 2'd1 && idx < 3'd3) begin
               held_in[idx[1:0]] = byte_ff;
            end
            left_in = left_ff - 2'd1;
            if (left_in == 2'd0) begin
               if ((seqlen_ff == 3'd2 && acc_in < Min2) ||
                   (seqlen_ff == 3'd3 && acc_in < Min3) ||
                   (seqlen_ff == 3'd4 && acc_in < Min4) || acc_in > MaxCode ||
                   (acc_in >= SurrLo && acc_in <= SurrHi)) begin
                  err_in = 1'b1;
               end else begin
                  whole = 1'b1;
               end
            end
         end
      end

      seqlen_whole = seqlen_in;
      if (whole) begin
         if (is_space(acc_in)) begin
            if (seen_ff) begin
               pend_in = 1'b1;
            end
         end else begin
            emit_text  = 1'b1;
            emit_space = pend_ff;
            pend_in    = 1'b0;
            seen_in    = 1'b1;
         end
         seqlen_in = 3'd0;
      end

      // The final byte of the codepoint lands right after the held bytes.
      for (int k = 0; k < 3; k++) begin
         c[k] = (seqlen_whole == 3'(k + 1)) ? byte_ff : held_in[k];
      end
      c[3] = byte_ff;

      if (emit_text) begin
         burst.data[0]    = emit_space ? SpaceByte : c[0];
         burst.data[1]    = emit_space ? c[0] : c[1];
         burst.data[2]    = emit_space ? c[1] : c[2];
         burst.data[3]    = emit_space ? c[2] : c[3];
         burst.data[4]    = emit_space ? c[3] : 8'h00;
         burst.count      = CountW'({2'b0, emit_space}) + CountW'(seqlen_whole);
         burst.byte_valid = 1'b1;
      end

      if (last_ff) begin
         if (left_in != 2'd0) begin
            err_in = 1'b1;
         end
         if (err_in || !emit_text) begin
            burst.data       = '0;
            burst.count      = CountW'(1);
            burst.byte_valid = 1'b0;
            burst.bad        = err_in;
         end
         burst.end_text = 1'b1;
         acc_in    = '0;
         left_in   = '0;
         seqlen_in = '0;
         seen_in   = 1'b0;
         pend_in   = 1'b0;
         err_in    = 1'b0;
      end
   end

   assign burst_valid = in_valid_ff && (burst.count != '0);
   assign advance     = in_valid_ff && (!burst_valid || load_ok);
   assign req_stall   = in_valid_ff && !advance;
   assign accept      = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         acc_ff      <= '0;
         left_ff     <= '0;
         seqlen_ff   <= '0;
         seen_ff     <= 1'b0;
         pend_ff     <= 1'b0;
         err_ff      <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            acc_ff    <= acc_in;
            left_ff   <= left_in;
            seqlen_ff <= seqlen_in;
            seen_ff   <= seen_in;
            pend_ff   <= pend_in;
            err_ff    <= err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_in_byte;
         last_ff <= req_last_byte;
      end
      if (advance) begin
         held_ff <= held_in;
      end
   end

endmodule

// ===== hw/rtl/utfwc_serialize.sv =====
module utfwc_serialize (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    burst_valid,
   input  utfwc_pkg::burst_type    burst,
   output logic                    load_ok,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_byte_valid,
   output logic                    rsp_run_last,
   output logic                    rsp_end_of_text,
   output logic                    rsp_bad_encoding
);
   import utfwc_pkg::*;

   logic              valid_ff;
   burst_type         burst_ff;
   logic [CountW-1:0] idx_ff;
   logic              take;
   logic              final_one;
   logic              done;

   assign take      = valid_ff && !rsp_stall;
   assign final_one = idx_ff == (burst_ff.count - CountW'(1));
   assign done      = take && final_one;
   assign load_ok   = !valid_ff || done;

   assign rsp_valid        = valid_ff;
   assign rsp_out_byte     = burst_ff.data[idx_ff];
   assign rsp_byte_valid   = burst_ff.byte_valid;
   assign rsp_run_last     = final_one;
   assign rsp_end_of_text  = burst_ff.end_text && final_one;
   assign rsp_bad_encoding = burst_ff.bad && final_one;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (burst_valid && load_ok) begin
         valid_ff <= 1'b1;
         idx_ff   <= '0;
      end else if (take) begin
         if (final_one) begin
            valid_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + CountW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (burst_valid && load_ok) begin
         burst_ff <= burst;
      end
   end

endmodule

// ===== hw/rtl/utf8_whitespace_collapse.sv =====
// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    in_byte[8], last_byte
// rsp_      out        rsp_valid/stall    out_byte[8], byte_valid, run_last,
//                                         end_of_text, bad_encoding
//
// A byte is decoded combinationally between the input register and the result
// register, and its first result appears once the result register loads it.
// A byte that yields k results (up to five) holds the result register until
// all k are taken, so the input accepts one byte per cycle except during such
// bursts or while rsp_stall holds. Reset is synchronous and clears all control
// and decoder state. rsp_stall holds the current result and, once the input
// register has a byte with results, stalls the request side in the same cycle.
module utf8_whitespace_collapse (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_run_last,
   output logic       rsp_end_of_text,
   output logic       rsp_bad_encoding
);
   import utfwc_pkg::*;

   burst_type burst;
   logic      burst_valid;
   logic      load_ok;

   utfwc_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_byte   (req_in_byte),
      .req_last_byte (req_last_byte),
      .load_ok       (load_ok),
      .burst_valid   (burst_valid),
      .burst         (burst)
   );

   utfwc_serialize u_serialize (
      .clock            (clock),
      .reset            (reset),
      .burst_valid      (burst_valid),
      .burst            (burst),
      .load_ok          (load_ok),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_run_last     (rsp_run_last),
      .rsp_end_of_text  (rsp_end_of_text),
      .rsp_bad_encoding (rsp_bad_encoding)
   );

endmodule

// ===== hw/rtl/utfwc_checker.sv =====
module utfwc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_in_byte,
   input logic       req_last_byte,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_byte_valid,
   input logic       rsp_run_last,
   input logic       rsp_end_of_text,
   input logic       rsp_bad_encoding
);

   // An error is reported only on the end transaction of a text.
   a_bad_on_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_encoding |-> rsp_end_of_text && !rsp_byte_valid)
      else $error("bad_encoding outside a bare end marker");

   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_text |-> rsp_run_last)
      else $error("end_of_text without run_last");

   a_bare_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_end_of_text && rsp_out_byte == 8'h00)
      else $error("bare marker that does not end the text");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) &&
                                 $stable(rsp_run_last))
      else $error("stalled result changed");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_in_byte) &&
                                 $stable(req_last_byte))
      else $error("stalled request changed");

endmodule

bind utf8_whitespace_collapse utfwc_checker u_checker (.*);
